[sv/tmbc_pkg.sv]
// Shared types and constants of the tile map box collision block.
package tmbc_pkg;

  // Field widths of one input word
  localparam int CELL_W = 7;
  localparam int BOX_W  = 24;

  // Item kind codes
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted input word
    logic calc;         // register cell bounds / write index, clear hit accumulator
    logic wr_rd;        // read the row addressed by the write index
    logic wr_commit;    // write back the row with one cell updated
    logic scan_rd;      // read the current scan row and step the column
    logic result_load;  // load the hit result into the output register
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_query;
    logic write_ok;     // write coordinates are nonzero and land inside the map
    logic empty;        // box covers no in-map cell
    logic x_last;       // scan column has reached the right bound
  } dp_sts_t;

endpackage

[sv/tmbc_if.sv]
// Valid/ready channel interfaces for input words and result words.
interface tmbc_in_if;
  import tmbc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [CELL_W-1:0] cell_x;
  logic signed [CELL_W-1:0] cell_y;
  logic                     occupied;
  logic signed [BOX_W-1:0]  box_left;
  logic signed [BOX_W-1:0]  box_top;
  logic signed [BOX_W-1:0]  box_right;
  logic signed [BOX_W-1:0]  box_bottom;

  modport source (
    output valid, kind, cell_x, cell_y, occupied, box_left, box_top, box_right, box_bottom,
    input  ready
  );
  modport sink (
    input  valid, kind, cell_x, cell_y, occupied, box_left, box_top, box_right, box_bottom,
    output ready
  );
endinterface

interface tmbc_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

[sv/tile_map_box_collision_core.sv]
// Top level of the tile map box collision block: controller, datapath and checks.
//
// Input channel in_i carries one word per item. kind 0 writes one map cell: cell_x and
// cell_y are signed 1-based coordinates with no zero, and a zero or off-map coordinate
// drops the write. kind 1 is a box query; the four box edges are floored to cells by an
// arithmetic shift of CELL_SHIFT and cells outside the map count as empty.
// Output channel out_o carries one word (hit) per query; writes give no word.
// Sequence: a write runs bound calc, row read, row write-back and back to idle after
// acceptance; a dropped write returns to idle after the bound calc. A query runs bound
// calc, then scans the in-map columns the box spans (none for an inverted or off-map
// box, at most MAP_CELLS); the column scan reads one stored row per cycle from the
// single-port row memory. The drain state then loads hit into the output register
// once that register is free.
// in_i.ready is high only while idle; one item is worked on at a time.
// Results sit in an output register, so a new item is taken while a result waits;
// a query that finishes while the previous hit is still unread holds until it is taken.
// Reset clears the controller and every row valid bit at once, so the whole map reads
// empty right after reset with no clearing pass.
module tile_map_box_collision_core #(
  parameter int MAP_CELLS  = 64,
  parameter int CELL_SHIFT = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmbc_in_if.sink    in_i,
  tmbc_out_if.source out_o
);
  import tmbc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  tmbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tmbc_datapath #(
    .MAP_CELLS  (MAP_CELLS),
    .CELL_SHIFT (CELL_SHIFT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (in_i.kind),
    .cell_x_i     (in_i.cell_x),
    .cell_y_i     (in_i.cell_y),
    .occupied_i   (in_i.occupied),
    .box_left_i   (in_i.box_left),
    .box_top_i    (in_i.box_top),
    .box_right_i  (in_i.box_right),
    .box_bottom_i (in_i.box_bottom),
    .hit_o        (out_o.hit)
  );

  // A new hit never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.result_load |-> !(out_o.valid && !out_o.ready))
    else $error("result loaded over an untaken word");

  // The block is not ready in the cycle after it accepts a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while previous item in flight");

  // Datapath work commands are mutually exclusive
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.calc, cmd.wr_rd, cmd.wr_commit, cmd.scan_rd, cmd.result_load}))
    else $error("more than one datapath command in a cycle");

  // Map rows change only for write items
  a_commit_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_commit |-> (!sts.is_query && sts.write_ok && $past(cmd.wr_rd)))
    else $error("row write-back outside a valid write item");

endmodule

[sv/tmbc_datapath.sv]
// Datapath: input word capture, cell bound math, occupancy row memory and hit accumulation.
module tmbc_datapath #(
  parameter int MAP_CELLS  = 64,
  parameter int CELL_SHIFT = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tmbc_pkg::ctrl_cmd_t              cmd_i,
  output tmbc_pkg::dp_sts_t                sts_o,
  input  logic                             kind_i,
  input  logic signed [tmbc_pkg::CELL_W-1:0] cell_x_i,
  input  logic signed [tmbc_pkg::CELL_W-1:0] cell_y_i,
  input  logic                             occupied_i,
  input  logic signed [tmbc_pkg::BOX_W-1:0]  box_left_i,
  input  logic signed [tmbc_pkg::BOX_W-1:0]  box_top_i,
  input  logic signed [tmbc_pkg::BOX_W-1:0]  box_right_i,
  input  logic signed [tmbc_pkg::BOX_W-1:0]  box_bottom_i,
  output logic                             hit_o
);
  import tmbc_pkg::*;

  localparam int IW  = $clog2(MAP_CELLS);
  localparam int WIW = CELL_W + 3;   // write index, holds -64+half .. 63+half-1
  localparam int QW  = BOX_W + 2;    // floored cell plus map offset

  localparam logic signed [WIW-1:0] HALF_W = WIW'(MAP_CELLS / 2);
  localparam logic signed [WIW-1:0] ONE_W  = WIW'(1);
  localparam logic signed [WIW-1:0] SIZE_W = WIW'(MAP_CELLS);
  localparam logic signed [QW-1:0]  HALF_Q = QW'(MAP_CELLS / 2);
  localparam logic signed [QW-1:0]  MAXC_Q = QW'(MAP_CELLS - 1);
  localparam logic [IW-1:0]         TOP_I  = IW'(MAP_CELLS - 1);

  typedef logic [MAP_CELLS-1:0] row_t;

  // 1-based signed coordinate (no zero) to map index
  function automatic logic signed [WIW-1:0] wr_index(input logic signed [CELL_W-1:0] c);
    logic signed [WIW-1:0] ce;
    ce = {{(WIW - CELL_W){c[CELL_W-1]}}, c};
    return ce + HALF_W - ((c > 0) ? ONE_W : '0);
  endfunction

  // World coordinate to map index; arithmetic shift is a true floor
  function automatic logic signed [QW-1:0] to_cell(input logic signed [BOX_W-1:0] v);
    logic signed [BOX_W-1:0] f;
    f = v >>> CELL_SHIFT;
    return {{(QW - BOX_W){f[BOX_W-1]}}, f} + HALF_Q;
  endfunction

  // Captured input word
  logic                     kind_q;
  logic signed [CELL_W-1:0] cx_q, cy_q;
  logic                     occ_q;
  logic signed [BOX_W-1:0]  left_q, top_q, right_q, bot_q;

  // Bounds computed in the calc cycle
  logic signed [WIW-1:0] ix_s, iy_s;
  logic signed [QW-1:0]  xlo_s, xhi_s, ylo_s, yhi_s;
  logic signed [QW-1:0]  xlo_c, xhi_c, ylo_c, yhi_c;
  logic                  wr_ok_d, empty_d;
  row_t                  mask_d;

  logic [IW-1:0] ix_q, iy_q, x_q, xhi_q;
  logic          wr_ok_q, empty_q;
  row_t          mask_q;

  // Row memory, indexed by column; one bit per row cell
  row_t          mem_q [MAP_CELLS];
  logic [MAP_CELLS-1:0] row_vld_q;
  row_t          mem_rd_q;
  logic          vld_rd_q;
  logic          rd_pend_q;
  logic [IW-1:0] rd_addr;
  row_t          row;
  row_t          new_row;

  logic acc_q, row_hit, hit_now, hit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      cx_q    <= cell_x_i;
      cy_q    <= cell_y_i;
      occ_q   <= occupied_i;
      left_q  <= box_left_i;
      top_q   <= box_top_i;
      right_q <= box_right_i;
      bot_q   <= box_bottom_i;
    end
  end

  always_comb begin
    ix_s    = wr_index(cx_q);
    iy_s    = wr_index(cy_q);
    wr_ok_d = (cx_q != '0) && (cy_q != '0) &&
              (ix_s >= 0) && (ix_s < SIZE_W) && (iy_s >= 0) && (iy_s < SIZE_W);

    xlo_s = to_cell(left_q);
    xhi_s = to_cell(right_q);
    ylo_s = to_cell(bot_q);
    yhi_s = to_cell(top_q);
    xlo_c = (xlo_s < 0) ? '0 : xlo_s;
    ylo_c = (ylo_s < 0) ? '0 : ylo_s;
    xhi_c = (xhi_s > MAXC_Q) ? MAXC_Q : xhi_s;
    yhi_c = (yhi_s > MAXC_Q) ? MAXC_Q : yhi_s;
    empty_d = (xlo_c > xhi_c) || (ylo_c > yhi_c);

    // rows ylo..yhi of each column word; only meaningful when the box is not empty
    mask_d = ({MAP_CELLS{1'b1}} << ylo_c[IW-1:0]) &
             ({MAP_CELLS{1'b1}} >> (TOP_I - yhi_c[IW-1:0]));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      ix_q    <= ix_s[IW-1:0];
      iy_q    <= iy_s[IW-1:0];
      wr_ok_q <= wr_ok_d;
      empty_q <= empty_d;
      xhi_q   <= xhi_c[IW-1:0];
      mask_q  <= mask_d;
      x_q     <= xlo_c[IW-1:0];
    end else if (cmd_i.scan_rd) begin
      x_q <= x_q + IW'(1);
    end
  end

  // Memory read/write; unwritten rows read as empty through the valid bits
  assign rd_addr = cmd_i.wr_rd ? ix_q : x_q;
  assign row     = vld_rd_q ? mem_rd_q : '0;

  always_comb begin
    new_row       = row;
    new_row[iy_q] = occ_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_rd || cmd_i.scan_rd) begin
      mem_rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.wr_commit) begin
      mem_q[ix_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      vld_rd_q  <= 1'b0;
      rd_pend_q <= 1'b0;
      acc_q     <= 1'b0;
    end else begin
      if (cmd_i.wr_commit) begin
        row_vld_q[ix_q] <= 1'b1;
      end
      if (cmd_i.wr_rd || cmd_i.scan_rd) begin
        vld_rd_q <= row_vld_q[rd_addr];
      end
      rd_pend_q <= cmd_i.scan_rd;
      if (cmd_i.calc) begin
        acc_q <= 1'b0;
      end else begin
        acc_q <= hit_now;
      end
    end
  end

  assign row_hit = |(row & mask_q);
  assign hit_now = acc_q | (rd_pend_q & row_hit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      hit_q <= hit_now;
    end
  end

  assign hit_o          = hit_q;
  assign sts_o.is_query = (kind_q == KIND_QUERY);
  assign sts_o.write_ok = wr_ok_q;
  assign sts_o.empty    = empty_q;
  assign sts_o.x_last   = (x_q == xhi_q);

endmodule

[sv/tmbc_ctrl.sv]
// Controller: sequences capture, write read-modify-write, column scan and result handoff.
module tmbc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmbc_pkg::ctrl_cmd_t cmd_o,
  input  tmbc_pkg::dp_sts_t   sts_i
);
  import tmbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_ROUTE,
    S_WR,
    S_SCAN,
    S_DRAIN
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  ctrl_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.capture = (state_q == S_IDLE) && in_valid_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_d  = S_ROUTE;
      end
      S_ROUTE: begin
        if (!sts_i.is_query) begin
          if (sts_i.write_ok) begin
            cmd.wr_rd = 1'b1;
            state_d   = S_WR;
          end else begin
            state_d = S_IDLE;
          end
        end else if (sts_i.empty) begin
          state_d = S_DRAIN;
        end else begin
          cmd.scan_rd = 1'b1;
          state_d     = sts_i.x_last ? S_DRAIN : S_SCAN;
        end
      end
      S_WR: begin
        cmd.wr_commit = 1'b1;
        state_d       = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts_i.x_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.result_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd.result_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule
